// ===== src/sst_pkg.sv =====
package sst_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int ENCODER_BITS_DEF = 16;

	localparam int LIGHT_W = 7;
	localparam int SPEED_W = 7;
	localparam int TOL_W = 7;
	localparam int INTERVAL_W = 20;
	localparam int DRIVE_W = 8;
	localparam int PHASE_W = 4;
	localparam int SENSOR_W = 3;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_TOLERANCE = 3'd0;
	localparam logic [2:0] REG_INTERVAL = 3'd1;
	localparam logic [2:0] REG_YAW_TRACK = 3'd2;
	localparam logic [2:0] REG_PITCH_TRACK = 3'd3;
	localparam logic [2:0] REG_PITCH_HOME = 3'd4;

	localparam logic [TOL_W-1:0] TOLERANCE_RST = 7'd10;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd5000;
	localparam logic [SPEED_W-1:0] YAW_TRACK_RST = 7'd10;
	localparam logic [SPEED_W-1:0] PITCH_TRACK_RST = 7'd10;
	localparam logic [SPEED_W-1:0] PITCH_HOME_RST = 7'd5;

	// phase codes as seen on the result channel
	localparam logic [PHASE_W-1:0] PH_PRESS = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 4'd1;
	localparam logic [PHASE_W-1:0] PH_CLASSIFY = 4'd2;
	localparam logic [PHASE_W-1:0] PH_YAW = 4'd3;
	localparam logic [PHASE_W-1:0] PH_PITCH = 4'd4;
	localparam logic [PHASE_W-1:0] PH_WAIT = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WAIT_REL = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RETURN = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SHUT_PITCH = 4'd8;
	localparam logic [PHASE_W-1:0] PH_SHUT_YAW = 4'd9;
	localparam logic [PHASE_W-1:0] PH_DONE = 4'd10;

	localparam logic [SENSOR_W-1:0] SENSOR_NONE = 3'd0;
	localparam logic [SENSOR_W-1:0] SENSOR_ONE = 3'd1;
	localparam logic [SENSOR_W-1:0] SENSOR_TWO = 3'd2;
	localparam logic [SENSOR_W-1:0] SENSOR_THREE = 3'd3;
	localparam logic [SENSOR_W-1:0] SENSOR_FOUR = 3'd4;

	typedef enum logic [10:0] {
		ST_PRESS      = 11'b000_0000_0001,
		ST_RELEASE    = 11'b000_0000_0010,
		ST_CLASSIFY   = 11'b000_0000_0100,
		ST_YAW        = 11'b000_0000_1000,
		ST_PITCH      = 11'b000_0001_0000,
		ST_WAIT       = 11'b000_0010_0000,
		ST_WAIT_REL   = 11'b000_0100_0000,
		ST_RETURN     = 11'b000_1000_0000,
		ST_SHUT_PITCH = 11'b001_0000_0000,
		ST_SHUT_YAW   = 11'b010_0000_0000,
		ST_DONE       = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic [INTERVAL_W-1:0] interval_ms;
		logic [SPEED_W-1:0] yaw_track_speed;
		logic [SPEED_W-1:0] pitch_track_speed;
		logic [SPEED_W-1:0] pitch_home_speed;
	} cfg_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] yaw_drive;
		logic [DRIVE_W-1:0] pitch_drive;
		logic [PHASE_W-1:0] phase;
		logic [SENSOR_W-1:0] brightest;
		logic finished;
	} res_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t st);
		logic [PHASE_W-1:0] code;
		unique case (st)
			ST_PRESS:      code = PH_PRESS;
			ST_RELEASE:    code = PH_RELEASE;
			ST_CLASSIFY:   code = PH_CLASSIFY;
			ST_YAW:        code = PH_YAW;
			ST_PITCH:      code = PH_PITCH;
			ST_WAIT:       code = PH_WAIT;
			ST_WAIT_REL:   code = PH_WAIT_REL;
			ST_RETURN:     code = PH_RETURN;
			ST_SHUT_PITCH: code = PH_SHUT_PITCH;
			ST_SHUT_YAW:   code = PH_SHUT_YAW;
			default:       code = PH_DONE;
		endcase
		return code;
	endfunction

endpackage

// ===== src/sst_if.sv =====
interface sst_item_if #(
	parameter int ENC_BITS = sst_pkg::ENCODER_BITS_DEF
);
	logic valid;
	logic ready;
	logic [sst_pkg::LIGHT_W-1:0] light_one;
	logic [sst_pkg::LIGHT_W-1:0] light_two;
	logic [sst_pkg::LIGHT_W-1:0] light_three;
	logic [sst_pkg::LIGHT_W-1:0] light_four;
	logic signed [ENC_BITS-1:0] pitch_count;
	logic signed [ENC_BITS-1:0] yaw_count;
	logic button;

	modport source (
		output valid, light_one, light_two, light_three, light_four,
		output pitch_count, yaw_count, button,
		input ready
	);
	modport sink (
		input valid, light_one, light_two, light_three, light_four,
		input pitch_count, yaw_count, button,
		output ready
	);
endinterface

interface sst_result_if;
	logic valid;
	logic ready;
	logic signed [sst_pkg::DRIVE_W-1:0] yaw_drive;
	logic signed [sst_pkg::DRIVE_W-1:0] pitch_drive;
	logic [sst_pkg::PHASE_W-1:0] phase;
	logic [sst_pkg::SENSOR_W-1:0] brightest;
	logic finished;

	modport source (
		output valid, yaw_drive, pitch_drive, phase, brightest, finished,
		input ready
	);
	modport sink (
		input valid, yaw_drive, pitch_drive, phase, brightest, finished,
		output ready
	);
endinterface

// ===== src/sst_apb_regs.sv =====
module sst_apb_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sst_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sst_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sst_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	output sst_pkg::cfg_t cfg
);

	sst_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance <= sst_pkg::TOLERANCE_RST;
			cfg_q.interval_ms <= sst_pkg::INTERVAL_RST;
			cfg_q.yaw_track_speed <= sst_pkg::YAW_TRACK_RST;
			cfg_q.pitch_track_speed <= sst_pkg::PITCH_TRACK_RST;
			cfg_q.pitch_home_speed <= sst_pkg::PITCH_HOME_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sst_pkg::REG_TOLERANCE:
					cfg_q.tolerance <= pwdata[sst_pkg::TOL_W-1:0];
				sst_pkg::REG_INTERVAL:
					cfg_q.interval_ms <= pwdata[sst_pkg::INTERVAL_W-1:0];
				sst_pkg::REG_YAW_TRACK:
					cfg_q.yaw_track_speed <= pwdata[sst_pkg::SPEED_W-1:0];
				sst_pkg::REG_PITCH_TRACK:
					cfg_q.pitch_track_speed <= pwdata[sst_pkg::SPEED_W-1:0];
				sst_pkg::REG_PITCH_HOME:
					cfg_q.pitch_home_speed <= pwdata[sst_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sst_pkg::REG_TOLERANCE:
				prdata = {{(sst_pkg::APB_DATA_W-sst_pkg::TOL_W){1'b0}}, cfg_q.tolerance};
			sst_pkg::REG_INTERVAL:
				prdata = {{(sst_pkg::APB_DATA_W-sst_pkg::INTERVAL_W){1'b0}}, cfg_q.interval_ms};
			sst_pkg::REG_YAW_TRACK:
				prdata = {{(sst_pkg::APB_DATA_W-sst_pkg::SPEED_W){1'b0}},
					cfg_q.yaw_track_speed};
			sst_pkg::REG_PITCH_TRACK:
				prdata = {{(sst_pkg::APB_DATA_W-sst_pkg::SPEED_W){1'b0}},
					cfg_q.pitch_track_speed};
			sst_pkg::REG_PITCH_HOME:
				prdata = {{(sst_pkg::APB_DATA_W-sst_pkg::SPEED_W){1'b0}},
					cfg_q.pitch_home_speed};
			default:
				prdata = '0;
		endcase
	end

endmodule

// ===== src/sst_core.sv =====
module sst_core #(
	parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF,
	parameter int ENC_BITS = sst_pkg::ENCODER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  sst_pkg::cfg_t cfg,
	input  logic [sst_pkg::LIGHT_W-1:0] light_one,
	input  logic [sst_pkg::LIGHT_W-1:0] light_two,
	input  logic [sst_pkg::LIGHT_W-1:0] light_three,
	input  logic [sst_pkg::LIGHT_W-1:0] light_four,
	input  logic [ENC_BITS-1:0] pitch_count,
	input  logic [ENC_BITS-1:0] yaw_count,
	input  logic button,
	output sst_pkg::res_t res
);

	localparam int LW = sst_pkg::LIGHT_W;
	localparam int DW = sst_pkg::DRIVE_W;
	localparam int IW = sst_pkg::INTERVAL_W;
	localparam int CMP_W = (COUNT_BITS > IW) ? COUNT_BITS : IW;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	sst_pkg::phase_t state_q, state_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic pair12_q, pair12_d;
	logic [sst_pkg::SENSOR_W-1:0] bright_q, bright_d, bright_pick;
	logic [DW-1:0] yaw_drv_q, yaw_drv_d;
	logic [DW-1:0] pitch_drv_q, pitch_drv_d;
	logic [ENC_BITS-1:0] home_off_q, home_off_d;

	logic dark;
	logic [LW+1:0] light_sum;
	logic bal12, bal34, bal13;
	logic [ENC_BITS:0] pitch_rel;
	logic pitch_home, pitch_pos, yaw_home, yaw_pos;
	logic wait_end;
	logic [DW-1:0] yaw_spd, yaw_spd_neg, ptrk_spd, ptrk_spd_neg, phome_spd, phome_spd_neg;

	function automatic logic is_bal(input logic [LW-1:0] a, input logic [LW-1:0] b,
		input logic [sst_pkg::TOL_W-1:0] tol);
		logic [LW-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return d <= tol;
	endfunction

	assign light_sum = {2'b00, light_one} + {2'b00, light_two}
		+ {2'b00, light_three} + {2'b00, light_four};
	// average of zero after truncation
	assign dark = light_sum < (LW+2)'(4);

	assign bal12 = is_bal(light_one, light_two, cfg.tolerance);
	assign bal34 = is_bal(light_three, light_four, cfg.tolerance);
	assign bal13 = is_bal(light_one, light_three, cfg.tolerance);

	always_comb begin
		if (light_one > light_two && light_one > light_three && light_one > light_four)
			bright_pick = sst_pkg::SENSOR_ONE;
		else if (light_two > light_one && light_two > light_three && light_two > light_four)
			bright_pick = sst_pkg::SENSOR_TWO;
		else if (light_three > light_one && light_three > light_two
			&& light_three > light_four)
			bright_pick = sst_pkg::SENSOR_THREE;
		else
			bright_pick = sst_pkg::SENSOR_FOUR;
	end

	assign pitch_rel = {pitch_count[ENC_BITS-1], pitch_count}
		- {home_off_q[ENC_BITS-1], home_off_q};
	assign pitch_home = (pitch_rel == '0) || (pitch_rel == {{ENC_BITS{1'b0}}, 1'b1})
		|| (pitch_rel == {(ENC_BITS+1){1'b1}});
	assign pitch_pos = !pitch_rel[ENC_BITS] && (pitch_rel != '0);
	assign yaw_home = (yaw_count == '0) || (yaw_count == {{(ENC_BITS-1){1'b0}}, 1'b1})
		|| (yaw_count == {ENC_BITS{1'b1}});
	assign yaw_pos = !yaw_count[ENC_BITS-1] && (yaw_count != '0);

	assign yaw_spd = {1'b0, cfg.yaw_track_speed};
	assign yaw_spd_neg = DW'(0) - yaw_spd;
	assign ptrk_spd = {1'b0, cfg.pitch_track_speed};
	assign ptrk_spd_neg = DW'(0) - ptrk_spd;
	assign phome_spd = {1'b0, cfg.pitch_home_speed};
	assign phome_spd_neg = DW'(0) - phome_spd;

	assign cnt_inc = (cnt_q != CNT_MAX) ? (cnt_q + COUNT_BITS'(1)) : cnt_q;
	assign wait_end = (CMP_W'(cnt_inc) >= CMP_W'(cfg.interval_ms)) || (cnt_inc == CNT_MAX);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pair12_d = pair12_q;
		bright_d = bright_q;
		yaw_drv_d = yaw_drv_q;
		pitch_drv_d = pitch_drv_q;
		home_off_d = home_off_q;
		unique case (state_q)
			sst_pkg::ST_PRESS: begin
				if (button)
					state_d = sst_pkg::ST_RELEASE;
			end
			sst_pkg::ST_RELEASE: begin
				if (!button)
					state_d = sst_pkg::ST_CLASSIFY;
			end
			sst_pkg::ST_CLASSIFY: begin
				if (dark) begin
					state_d = sst_pkg::ST_SHUT_PITCH;
				end else begin
					bright_d = bright_pick;
					pair12_d = (bright_pick == sst_pkg::SENSOR_ONE)
						|| (bright_pick == sst_pkg::SENSOR_TWO);
					yaw_drv_d = ((bright_pick == sst_pkg::SENSOR_ONE)
						|| (bright_pick == sst_pkg::SENSOR_THREE)) ? yaw_spd_neg : yaw_spd;
					state_d = sst_pkg::ST_YAW;
				end
			end
			sst_pkg::ST_YAW: begin
				if (pair12_q ? bal12 : bal34) begin
					yaw_drv_d = '0;
					if (light_one > light_three)
						pitch_drv_d = ptrk_spd;
					else if (light_one < light_three)
						pitch_drv_d = ptrk_spd_neg;
					else
						pitch_drv_d = '0;
					state_d = sst_pkg::ST_PITCH;
				end
			end
			sst_pkg::ST_PITCH: begin
				if (bal13) begin
					pitch_drv_d = '0;
					cnt_d = '0;
					state_d = sst_pkg::ST_WAIT;
				end
			end
			sst_pkg::ST_WAIT: begin
				if (button) begin
					state_d = sst_pkg::ST_WAIT_REL;
				end else begin
					cnt_d = cnt_inc;
					if (wait_end)
						state_d = sst_pkg::ST_RETURN;
				end
			end
			sst_pkg::ST_WAIT_REL: begin
				if (!button)
					state_d = sst_pkg::ST_SHUT_PITCH;
			end
			sst_pkg::ST_RETURN: begin
				if (pitch_home) begin
					pitch_drv_d = '0;
					home_off_d = pitch_count;
					state_d = sst_pkg::ST_CLASSIFY;
				end else begin
					pitch_drv_d = pitch_pos ? phome_spd_neg : phome_spd;
				end
			end
			sst_pkg::ST_SHUT_PITCH: begin
				if (pitch_home) begin
					pitch_drv_d = '0;
					state_d = sst_pkg::ST_SHUT_YAW;
				end else begin
					pitch_drv_d = pitch_pos ? phome_spd_neg : phome_spd;
				end
			end
			sst_pkg::ST_SHUT_YAW: begin
				if (yaw_home) begin
					yaw_drv_d = '0;
					state_d = sst_pkg::ST_DONE;
				end else begin
					yaw_drv_d = yaw_pos ? yaw_spd_neg : yaw_spd;
				end
			end
			default: begin
				yaw_drv_d = '0;
				pitch_drv_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sst_pkg::ST_PRESS;
			cnt_q <= '0;
			pair12_q <= 1'b0;
			bright_q <= sst_pkg::SENSOR_NONE;
			yaw_drv_q <= '0;
			pitch_drv_q <= '0;
			home_off_q <= '0;
		end else if (fire) begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pair12_q <= pair12_d;
			bright_q <= bright_d;
			yaw_drv_q <= yaw_drv_d;
			pitch_drv_q <= pitch_drv_d;
			home_off_q <= home_off_d;
		end
	end

	assign res.yaw_drive = yaw_drv_d;
	assign res.pitch_drive = pitch_drv_d;
	assign res.phase = sst_pkg::phase_code(state_d);
	assign res.brightest = bright_d;
	assign res.finished = (state_d == sst_pkg::ST_DONE);

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("phase register lost its one-hot code");

	a_done_motors_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_DONE) |-> (yaw_drv_q == '0 && pitch_drv_q == '0))
		else $error("motor driven after shutdown");

	a_wait_motors_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_WAIT) |-> (yaw_drv_q == '0 && pitch_drv_q == '0))
		else $error("motor driven during wait");

	a_pitch_yaw_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_PITCH) |-> (yaw_drv_q == '0))
		else $error("yaw driven while balancing pitch");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q) && $stable(cnt_q) && $stable(home_off_q))
		else $error("state moved without a tick");
`endif

endmodule

// ===== src/four_sensor_sun_tracker.sv =====
// Four-sensor sun tracker.
// The item channel carries one 1 ms tick: four light samples, the pitch and
// yaw encoder counts and the enter button level. The result channel returns
// exactly one result per tick: yaw and pitch drive, phase, the last chosen
// brightest sensor and a finished flag. Both channels transfer on valid and
// ready high at a rising clock edge.
// A tick is captured in an input register; the sequencer then evaluates it
// against the tracker state and loads the output register, from which the
// result is offered on the result channel. One tick is taken per cycle as
// long as the result side keeps up.
// When the receiver stalls, the result holds in the output register and one
// more tick may be taken into the input register; item ready then drops
// until the result transfers.
// Reset clears both pipeline valid flags and puts the tracker in the await
// press phase with all drives at zero and the register file at its defaults.
// The APB registers (tolerance, interval, three speeds) should be written
// only while no tick is in flight.
module four_sensor_sun_tracker #(
	parameter int COUNT_BITS = sst_pkg::COUNT_BITS_DEF,
	parameter int ENCODER_BITS = sst_pkg::ENCODER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sst_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sst_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sst_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	sst_item_if.sink item,
	sst_result_if.source result
);

	sst_pkg::cfg_t cfg;
	sst_pkg::res_t res_d, res_q;
	logic valid_s1, res_valid_q;
	logic advance, fire;
	logic [sst_pkg::LIGHT_W-1:0] light_one_s1, light_two_s1, light_three_s1, light_four_s1;
	logic [ENCODER_BITS-1:0] pitch_count_s1, yaw_count_s1;
	logic button_s1;

	sst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance = !res_valid_q || result.ready;
	assign fire = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			light_one_s1 <= item.light_one;
			light_two_s1 <= item.light_two;
			light_three_s1 <= item.light_three;
			light_four_s1 <= item.light_four;
			pitch_count_s1 <= item.pitch_count;
			yaw_count_s1 <= item.yaw_count;
			button_s1 <= item.button;
		end
	end

	sst_core #(
		.COUNT_BITS (COUNT_BITS),
		.ENC_BITS   (ENCODER_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.cfg         (cfg),
		.light_one   (light_one_s1),
		.light_two   (light_two_s1),
		.light_three (light_three_s1),
		.light_four  (light_four_s1),
		.pitch_count (pitch_count_s1),
		.yaw_count   (yaw_count_s1),
		.button      (button_s1),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

	assign result.valid = res_valid_q;
	assign result.yaw_drive = res_q.yaw_drive;
	assign result.pitch_drive = res_q.pitch_drive;
	assign result.phase = res_q.phase;
	assign result.brightest = res_q.brightest;
	assign result.finished = res_q.finished;

endmodule

// ===== test/tb_four_sensor_sun_tracker.sv =====
module tb_four_sensor_sun_tracker;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SEGMENTS = 8;
	localparam int SEGMENT_TICKS = 175;
	localparam int LW = sst_pkg::LIGHT_W;
	localparam int EW = sst_pkg::ENCODER_BITS_DEF;
	localparam int DW = sst_pkg::DRIVE_W;

	typedef struct {
		logic [LW-1:0] light [4];
		logic signed [EW-1:0] pitch_count;
		logic signed [EW-1:0] yaw_count;
		logic button;
	} tick_t;

	class sun_tracker_checker;
		logic [sst_pkg::TOL_W-1:0] tolerance;
		logic [sst_pkg::INTERVAL_W-1:0] interval_ms;
		logic [sst_pkg::SPEED_W-1:0] yaw_speed;
		logic [sst_pkg::SPEED_W-1:0] pitch_speed;
		logic [sst_pkg::SPEED_W-1:0] home_speed;

		logic [sst_pkg::PHASE_W-1:0] phase;
		logic [sst_pkg::COUNT_BITS_DEF-1:0] wait_ticks;
		bit pair_one_two;
		logic [sst_pkg::SENSOR_W-1:0] brightest;
		logic signed [DW-1:0] yaw_drive;
		logic signed [DW-1:0] pitch_drive;
		logic signed [EW-1:0] pitch_zero;

		sst_pkg::res_t drives_due [$];
		int failures;

		function new();
			tolerance = sst_pkg::TOLERANCE_RST;
			interval_ms = sst_pkg::INTERVAL_RST;
			yaw_speed = sst_pkg::YAW_TRACK_RST;
			pitch_speed = sst_pkg::PITCH_TRACK_RST;
			home_speed = sst_pkg::PITCH_HOME_RST;
			phase = sst_pkg::PH_PRESS;
			wait_ticks = '0;
			pair_one_two = 1'b0;
			brightest = sst_pkg::SENSOR_NONE;
			yaw_drive = '0;
			pitch_drive = '0;
			pitch_zero = '0;
			failures = 0;
		endfunction

		function void set_reg(logic [2:0] index, logic [31:0] value);
			case (index)
				sst_pkg::REG_TOLERANCE: tolerance = value[sst_pkg::TOL_W-1:0];
				sst_pkg::REG_INTERVAL: interval_ms = value[sst_pkg::INTERVAL_W-1:0];
				sst_pkg::REG_YAW_TRACK: yaw_speed = value[sst_pkg::SPEED_W-1:0];
				sst_pkg::REG_PITCH_TRACK: pitch_speed = value[sst_pkg::SPEED_W-1:0];
				sst_pkg::REG_PITCH_HOME: home_speed = value[sst_pkg::SPEED_W-1:0];
				default: ;
			endcase
		endfunction

		function bit balanced(int a, int b);
			int d;
			d = a - b;
			if (d < 0)
				d = -d;
			return d <= int'(tolerance);
		endfunction

		function bit at_home(int pos);
			return pos >= -1 && pos <= 1;
		endfunction

		function logic signed [DW-1:0] toward_home(int pos, int speed);
			return DW'((pos > 0) ? -speed : speed);
		endfunction

		// advance the tracker by one accepted tick and queue the drives it produces
		function void note_tick(tick_t t);
			int l1, l2, l3, l4, pitch, yaw;
			sst_pkg::res_t r;
			l1 = int'(t.light[0]);
			l2 = int'(t.light[1]);
			l3 = int'(t.light[2]);
			l4 = int'(t.light[3]);
			pitch = int'(t.pitch_count) - int'(pitch_zero);
			yaw = int'(t.yaw_count);
			case (phase)
				sst_pkg::PH_PRESS: if (t.button) phase = sst_pkg::PH_RELEASE;
				sst_pkg::PH_RELEASE: if (!t.button) phase = sst_pkg::PH_CLASSIFY;
				sst_pkg::PH_CLASSIFY: begin
					if ((l1 + l2 + l3 + l4) / 4 == 0) begin
						phase = sst_pkg::PH_SHUT_PITCH;
					end else begin
						if (l1 > l2 && l1 > l3 && l1 > l4)
							brightest = sst_pkg::SENSOR_ONE;
						else if (l2 > l1 && l2 > l3 && l2 > l4)
							brightest = sst_pkg::SENSOR_TWO;
						else if (l3 > l1 && l3 > l2 && l3 > l4)
							brightest = sst_pkg::SENSOR_THREE;
						else
							brightest = sst_pkg::SENSOR_FOUR;
						pair_one_two = (brightest == sst_pkg::SENSOR_ONE
							|| brightest == sst_pkg::SENSOR_TWO);
						yaw_drive = DW'((brightest == sst_pkg::SENSOR_ONE
							|| brightest == sst_pkg::SENSOR_THREE) ?
							-int'(yaw_speed) : int'(yaw_speed));
						phase = sst_pkg::PH_YAW;
					end
				end
				sst_pkg::PH_YAW: begin
					if (pair_one_two ? balanced(l1, l2) : balanced(l3, l4)) begin
						yaw_drive = '0;
						if (l1 > l3)
							pitch_drive = DW'(int'(pitch_speed));
						else if (l1 < l3)
							pitch_drive = DW'(-int'(pitch_speed));
						else
							pitch_drive = '0;
						phase = sst_pkg::PH_PITCH;
					end
				end
				sst_pkg::PH_PITCH: begin
					if (balanced(l1, l3)) begin
						pitch_drive = '0;
						wait_ticks = '0;
						phase = sst_pkg::PH_WAIT;
					end
				end
				sst_pkg::PH_WAIT: begin
					if (t.button) begin
						phase = sst_pkg::PH_WAIT_REL;
					end else begin
						if (wait_ticks != '1)
							wait_ticks++;
						if (wait_ticks >= interval_ms || wait_ticks == '1)
							phase = sst_pkg::PH_RETURN;
					end
				end
				sst_pkg::PH_WAIT_REL: if (!t.button) phase = sst_pkg::PH_SHUT_PITCH;
				sst_pkg::PH_RETURN: begin
					if (at_home(pitch)) begin
						pitch_drive = '0;
						pitch_zero = t.pitch_count;
						phase = sst_pkg::PH_CLASSIFY;
					end else begin
						pitch_drive = toward_home(pitch, int'(home_speed));
					end
				end
				sst_pkg::PH_SHUT_PITCH: begin
					if (at_home(pitch)) begin
						pitch_drive = '0;
						phase = sst_pkg::PH_SHUT_YAW;
					end else begin
						pitch_drive = toward_home(pitch, int'(home_speed));
					end
				end
				sst_pkg::PH_SHUT_YAW: begin
					if (at_home(yaw)) begin
						yaw_drive = '0;
						phase = sst_pkg::PH_DONE;
					end else begin
						yaw_drive = toward_home(yaw, int'(yaw_speed));
					end
				end
				default: begin
					yaw_drive = '0;
					pitch_drive = '0;
				end
			endcase
			r.yaw_drive = yaw_drive;
			r.pitch_drive = pitch_drive;
			r.phase = phase;
			r.brightest = brightest;
			r.finished = (phase >= sst_pkg::PH_DONE);
			drives_due.push_back(r);
		endfunction

		function void check_field(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(sst_pkg::res_t got);
			sst_pkg::res_t want;
			if (drives_due.size() == 0) begin
				$error("result transfer with no tick awaiting it");
				failures++;
				return;
			end
			want = drives_due.pop_front();
			check_field("yaw_drive", 32'($signed(want.yaw_drive)),
				32'($signed(got.yaw_drive)));
			check_field("pitch_drive", 32'($signed(want.pitch_drive)),
				32'($signed(got.pitch_drive)));
			check_field("phase", 32'(want.phase), 32'(got.phase));
			check_field("brightest", 32'(want.brightest), 32'(got.brightest));
			check_field("finished", 32'(want.finished), 32'(got.finished));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [sst_pkg::APB_ADDR_W-1:0] paddr;
	logic [sst_pkg::APB_DATA_W-1:0] pwdata;
	logic [sst_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	sst_item_if item_ch ();
	sst_result_if result_ch ();

	sun_tracker_checker sb = new();
	sst_pkg::res_t seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	bit dark_shutdown = 1'b0;

	four_sensor_sun_tracker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.yaw_drive = result_ch.yaw_drive;
			seen.pitch_drive = result_ch.pitch_drive;
			seen.phase = result_ch.phase;
			seen.brightest = result_ch.brightest;
			seen.finished = result_ch.finished;
			sb.check_result(seen);
		end
		result_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
	end

	task automatic write_reg(logic [2:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(index, value);
	endtask

	task automatic apply_settings(int tol, int interval, int yaw_sp, int pitch_sp, int home_sp);
		write_reg(sst_pkg::REG_TOLERANCE, 32'(tol));
		write_reg(sst_pkg::REG_INTERVAL, 32'(interval));
		write_reg(sst_pkg::REG_YAW_TRACK, 32'(yaw_sp));
		write_reg(sst_pkg::REG_PITCH_TRACK, 32'(pitch_sp));
		write_reg(sst_pkg::REG_PITCH_HOME, 32'(home_sp));
	endtask

	task automatic drain();
		while (sb.drives_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_tick(tick_t t);
		while (int'($urandom_range(99)) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.light_one <= t.light[0];
		item_ch.light_two <= t.light[1];
		item_ch.light_three <= t.light[2];
		item_ch.light_four <= t.light[3];
		item_ch.pitch_count <= t.pitch_count;
		item_ch.yaw_count <= t.yaw_count;
		item_ch.button <= t.button;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_tick(t);
	endtask

	task automatic send_sample(int l1, int l2, int l3, int l4, int pc, int yc, bit b);
		tick_t t;
		t.light[0] = LW'(l1);
		t.light[1] = LW'(l2);
		t.light[2] = LW'(l3);
		t.light[3] = LW'(l4);
		t.pitch_count = EW'(pc);
		t.yaw_count = EW'(yc);
		t.button = b;
		send_tick(t);
	endtask

	function automatic logic [LW-1:0] rand_light();
		return LW'(($urandom_range(15) == 0) ? $urandom_range(127, 101) : $urandom_range(100));
	endfunction

	// a sample within tolerance of ref, or just one step outside it
	function automatic logic [LW-1:0] near(int ref_val, int tol);
		int d, v;
		d = int'($urandom_range(tol + 1));
		if ($urandom_range(1) != 0)
			d = -d;
		v = ref_val + d;
		if (v < 0)
			v = 0;
		if (v > 127)
			v = 127;
		return LW'(v);
	endfunction

	function automatic logic signed [EW-1:0] near_home(int zero);
		int v;
		v = zero + int'($urandom_range(4)) - 2;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return EW'(v);
	endfunction

	// tick content shaped by the phase the tracker is in, so passes keep completing
	function automatic tick_t make_tick(bit closing);
		tick_t t;
		int tol, sum;
		tol = int'(sb.tolerance);
		for (int i = 0; i < 4; i++)
			t.light[i] = rand_light();
		t.pitch_count = EW'($urandom);
		t.yaw_count = EW'($urandom);
		t.button = 1'($urandom_range(1));
		case (sb.phase)
			sst_pkg::PH_PRESS: t.button = ($urandom_range(9) < 6);
			sst_pkg::PH_RELEASE: t.button = ($urandom_range(9) < 4);
			sst_pkg::PH_CLASSIFY: begin
				if (closing && dark_shutdown) begin
					t.light[0] = LW'($urandom_range(1));
					t.light[1] = LW'($urandom_range(1));
					t.light[2] = LW'($urandom_range(1));
					t.light[3] = '0;
				end else begin
					// narrow band makes ties for the top sample common
					if ($urandom_range(2) == 0)
						for (int i = 0; i < 4; i++)
							t.light[i] = LW'($urandom_range(52, 50));
					sum = int'(t.light[0]) + int'(t.light[1])
						+ int'(t.light[2]) + int'(t.light[3]);
					if (sum < 4)
						t.light[0] = LW'($urandom_range(100, 4));
				end
			end
			sst_pkg::PH_YAW: begin
				if ($urandom_range(5) == 0)
					t.light[2] = t.light[0];
				if ($urandom_range(1) != 0) begin
					if (sb.pair_one_two)
						t.light[1] = near(int'(t.light[0]), tol);
					else
						t.light[3] = near(int'(t.light[2]), tol);
				end
			end
			sst_pkg::PH_PITCH:
				if ($urandom_range(1) != 0) t.light[2] = near(int'(t.light[0]), tol);
			sst_pkg::PH_WAIT: t.button = closing && ($urandom_range(2) == 0);
			sst_pkg::PH_WAIT_REL: t.button = ($urandom_range(2) != 0);
			sst_pkg::PH_RETURN, sst_pkg::PH_SHUT_PITCH: begin
				if ($urandom_range(9) < 4)
					t.pitch_count = near_home(int'(sb.pitch_zero));
			end
			sst_pkg::PH_SHUT_YAW: if ($urandom_range(9) < 4) t.yaw_count = near_home(0);
			default: ;
		endcase
		return t;
	endfunction

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.light_one <= '0;
		item_ch.light_two <= '0;
		item_ch.light_three <= '0;
		item_ch.light_four <= '0;
		item_ch.pitch_count <= '0;
		item_ch.yaw_count <= '0;
		item_ch.button <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: press, release, all-tie classify, yaw on pair 3/4, pitch
		send_sample(0, 0, 0, 0, 32767, -32768, 0);
		send_sample(127, 127, 127, 127, -32768, 32767, 1);
		send_sample(127, 127, 127, 127, 0, 0, 1);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(1, 1, 1, 1, 0, 0, 0);
		send_sample(40, 0, 20, 31, 0, 0, 1);
		send_sample(40, 0, 20, 30, 0, 0, 0);
		send_sample(40, 0, 29, 0, 0, 0, 1);
		send_sample(40, 0, 30, 0, 0, 0, 0);
		item_ch.valid <= 1'b0;
		drain();
		// zero interval behaves as one tick; tolerance zero; speeds past 100
		apply_settings(0, 0, 127, 127, 127);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 100, 0, 1);
		send_sample(0, 0, 0, 0, -2, 0, 0);
		send_sample(0, 0, 0, 0, 1, 0, 0);
		send_sample(100, 99, 99, 99, 0, 0, 0);
		send_sample(5, 5, 5, 0, 0, 0, 0);
		send_sample(5, 0, 5, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 2, 0, 0);
		send_sample(10, 60, 59, 58, 0, 0, 0);
		send_sample(0, 1, 100, 0, 0, 0, 0);
		send_sample(0, 0, 100, 0, 0, 0, 0);
		send_sample(0, 0, 100, 0, 0, 0, 0);
		send_sample(127, 0, 127, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 2, 0, 0);
		item_ch.valid <= 1'b0;

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: apply_settings(0, 1, 0, 0, 0);
				1: apply_settings(127, 12, 127, 127, 127);
				2: apply_settings(100, 3, 100, 100, 100);
				default: apply_settings(int'($urandom_range(12)), int'($urandom_range(10)),
					int'($urandom_range(127)), int'($urandom_range(127)),
					int'($urandom_range(127)));
			endcase
			case (seg % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 73; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 73; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int n = 0; n < SEGMENT_TICKS; n++)
				send_tick(make_tick(1'b0));
			item_ch.valid <= 1'b0;
		end

		// shutdown is terminal: either a dark classify or a press during the wait
		drain();
		dark_shutdown = 1'($urandom_range(1));
		apply_settings(int'($urandom_range(20)), (1 << sst_pkg::INTERVAL_W) - 1,
			int'($urandom_range(100, 1)), int'($urandom_range(100, 1)),
			int'($urandom_range(100, 1)));
		idle_pct = 20;
		stall_pct = 20;
		while (sb.phase != sst_pkg::PH_DONE)
			send_tick(make_tick(1'b1));
		repeat (6) send_tick(make_tick(1'b1));
		item_ch.valid <= 1'b0;

		while (sb.drives_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.drives_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
